>>> rtl/stt_pkg.sv
// Package for the source text tokenizer: result type, pending-token codes, kinds and classifiers.
`timescale 1ns / 1ps

package stt_pkg;

    localparam int DEF_POSITION_BITS    = 16;
    localparam int DEF_MAX_TOKEN_LENGTH = 255;

    // Token kind codes as seen on the result channel.
    localparam logic [4:0] KIND_EOF     = 5'd0;
    localparam logic [4:0] KIND_KEYWORD = 5'd1;
    localparam logic [4:0] KIND_IDENT   = 5'd2;
    localparam logic [4:0] KIND_NUMBER  = 5'd3;
    localparam logic [4:0] KIND_LPAREN  = 5'd4;
    localparam logic [4:0] KIND_RPAREN  = 5'd5;
    localparam logic [4:0] KIND_LBRACE  = 5'd6;
    localparam logic [4:0] KIND_RBRACE  = 5'd7;
    localparam logic [4:0] KIND_COMMA   = 5'd8;
    localparam logic [4:0] KIND_COLON   = 5'd9;
    localparam logic [4:0] KIND_ASSIGN  = 5'd10;
    localparam logic [4:0] KIND_PLUS    = 5'd11;
    localparam logic [4:0] KIND_MINUS   = 5'd12;
    localparam logic [4:0] KIND_STAR    = 5'd13;
    localparam logic [4:0] KIND_SLASH   = 5'd14;
    localparam logic [4:0] KIND_PERCENT = 5'd15;
    localparam logic [4:0] KIND_DOT     = 5'd16;
    localparam logic [4:0] KIND_ARROW   = 5'd17;
    localparam logic [4:0] KIND_EQEQ    = 5'd18;

    localparam logic [1:0] KW_NONE   = 2'd0;
    localparam logic [1:0] KW_FN     = 2'd1;
    localparam logic [1:0] KW_RETURN = 2'd2;

    localparam logic [7:0] CHAR_NUL        = 8'h00;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_DOT        = 8'h2E;
    localparam logic [7:0] CHAR_GT         = 8'h3E;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] CHAR_EQUAL      = 8'h3D;
    localparam logic [7:0] CHAR_F          = 8'h66;
    localparam logic [7:0] CHAR_N          = 8'h6E;

    typedef enum logic [2:0] {
        PK_NONE,
        PK_IDENT,
        PK_NUMBER,
        PK_MINUS,
        PK_EQUAL
    } pend_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] offset;
        logic [7:0]  length;
        logic [1:0]  which;
        logic        last;
    } token_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Character of "return" at a given index; index is below six.
    function automatic logic [7:0] return_char(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'h72;
            3'd1:    return 8'h65;
            3'd2:    return 8'h74;
            3'd3:    return 8'h75;
            3'd4:    return 8'h72;
            3'd5:    return 8'h6E;
            default: return 8'h00;
        endcase
    endfunction

    // Kind of a single-character token, or KIND_EOF when the byte is not one.
    function automatic logic [4:0] single_kind(input logic [7:0] c);
        case (c)
            8'h28:   return KIND_LPAREN;
            8'h29:   return KIND_RPAREN;
            8'h7B:   return KIND_LBRACE;
            8'h7D:   return KIND_RBRACE;
            8'h2C:   return KIND_COMMA;
            8'h3A:   return KIND_COLON;
            8'h2B:   return KIND_PLUS;
            8'h2A:   return KIND_STAR;
            8'h2F:   return KIND_SLASH;
            8'h25:   return KIND_PERCENT;
            8'h2E:   return KIND_DOT;
            default: return KIND_EOF;
        endcase
    endfunction

endpackage

>>> rtl/source_text_tokenizer_core.sv
// Top level of the source text tokenizer: byte classification, token state and result queue.
`timescale 1ns / 1ps

// Takes one text byte per cycle, while the result queue has room, and emits tokens
// (kind, start offset, length, keyword flag). Each accepted byte yields zero, one or two
// tokens; m_tlast marks the last token of a byte. The result side delivers one token per
// cycle from a four-entry queue, and the input accepts a byte whenever that queue holds at
// most two tokens, so a stream sustains one byte per cycle while the consumer keeps up; a
// byte that closes one token and is itself a token or the end of text yields two tokens.
// A zero byte ends the text, emits any pending token and an EOF token, and returns all
// state to reset. Tokens enter the result queue at the edge that accepts their byte.
module source_text_tokenizer_core #(
    parameter int POSITION_BITS    = stt_pkg::DEF_POSITION_BITS,
    parameter int MAX_TOKEN_LENGTH = stt_pkg::DEF_MAX_TOKEN_LENGTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [4:0] token_kind, [20:5] token_offset,
                                   // [28:21] token_length, [30:29] keyword_which, [31] zero
    output logic        m_tlast    // last_of_run
);

    localparam int CW    = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int LW    = (CW > 8) ? CW : 8;
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int QW    = $clog2(DEPTH + 1);

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    stt_pkg::pend_t           pend_reg, pend_next;
    logic                     dot_reg, dot_next;
    logic                     fn_reg, fn_next;
    logic                     ret_reg, ret_next;

    stt_pkg::token_t          queue_reg [DEPTH];
    logic [AW-1:0]            wr_ptr_reg, rd_ptr_reg;
    logic [QW-1:0]            count_reg;

    logic                     accept, pop;
    logic [7:0]               c;
    logic [15:0]              pos_off, start_off;
    logic [LW-1:0]            cnt_wide;
    logic [7:0]               cnt_len;
    logic                     fn_hit, ret_hit;
    stt_pkg::token_t          flush_tok, tok_a, tok_b, first_tok;
    logic                     tok_a_v, tok_b_v;
    logic [1:0]               push_n;
    logic                     done;
    logic [4:0]               single;

    assign accept = s_tvalid && s_tready;
    assign pop    = m_tvalid && m_tready;
    assign c      = s_tdata;

    generate
        if (POSITION_BITS >= 16) begin : g_off_wide
            assign pos_off   = pos_reg[15:0];
            assign start_off = start_reg[15:0];
        end else begin : g_off_narrow
            assign pos_off   = {{(16-POSITION_BITS){1'b0}}, pos_reg};
            assign start_off = {{(16-POSITION_BITS){1'b0}}, start_reg};
        end
    endgenerate

    assign cnt_wide = LW'(cnt_reg);
    assign cnt_len  = (cnt_wide > LW'(255)) ? 8'hFF : cnt_wide[7:0];

    assign fn_hit  = (cnt_reg == CW'(0) && c == stt_pkg::CHAR_F) ||
                     (cnt_reg == CW'(1) && c == stt_pkg::CHAR_N);
    assign ret_hit = (cnt_reg < CW'(6)) && (c == stt_pkg::return_char(cnt_reg[2:0]));
    assign single  = stt_pkg::single_kind(c);

    // Token that the pending state closes when the next byte does not extend it.
    always_comb begin
        flush_tok        = '0;
        flush_tok.offset = start_off;
        case (pend_reg)
            stt_pkg::PK_IDENT: begin
                flush_tok.length = cnt_len;
                if (fn_reg && cnt_reg == CW'(2)) begin
                    flush_tok.kind  = stt_pkg::KIND_KEYWORD;
                    flush_tok.which = stt_pkg::KW_FN;
                end else if (ret_reg && cnt_reg == CW'(6)) begin
                    flush_tok.kind  = stt_pkg::KIND_KEYWORD;
                    flush_tok.which = stt_pkg::KW_RETURN;
                end else begin
                    flush_tok.kind  = stt_pkg::KIND_IDENT;
                end
            end
            stt_pkg::PK_NUMBER: begin
                flush_tok.kind   = stt_pkg::KIND_NUMBER;
                flush_tok.length = cnt_len;
            end
            stt_pkg::PK_MINUS: begin
                flush_tok.kind   = stt_pkg::KIND_MINUS;
                flush_tok.length = 8'd1;
            end
            stt_pkg::PK_EQUAL: begin
                flush_tok.kind   = stt_pkg::KIND_ASSIGN;
                flush_tok.length = 8'd1;
            end
            default: ;
        endcase
    end

    always_comb begin
        pend_next  = pend_reg;
        start_next = start_reg;
        cnt_next   = cnt_reg;
        dot_next   = dot_reg;
        fn_next    = fn_reg;
        ret_next   = ret_reg;
        pos_next   = pos_reg;
        tok_a      = '0;
        tok_b      = '0;
        tok_a_v    = 1'b0;
        tok_b_v    = 1'b0;
        done       = 1'b0;

        if (accept) begin
            pos_next = (&pos_reg) ? pos_reg : pos_reg + POSITION_BITS'(1);

            case (pend_reg)
                stt_pkg::PK_IDENT: begin
                    if (stt_pkg::is_letter(c) || stt_pkg::is_numeral(c) ||
                        c == stt_pkg::CHAR_UNDERSCORE) begin
                        done = 1'b1;
                        if (cnt_reg >= CW'(MAX_TOKEN_LENGTH)) begin
                            // A saturated identifier can no longer be a keyword.
                            fn_next  = 1'b0;
                            ret_next = 1'b0;
                        end else begin
                            if (!fn_hit) begin
                                fn_next = 1'b0;
                            end
                            if (!ret_hit) begin
                                ret_next = 1'b0;
                            end
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end else begin
                        tok_a_v   = 1'b1;
                        tok_a     = flush_tok;
                        pend_next = stt_pkg::PK_NONE;
                    end
                end
                stt_pkg::PK_NUMBER: begin
                    if (stt_pkg::is_numeral(c) || (c == stt_pkg::CHAR_DOT && !dot_reg)) begin
                        done = 1'b1;
                        if (c == stt_pkg::CHAR_DOT) begin
                            dot_next = 1'b1;
                        end
                        if (cnt_reg < CW'(MAX_TOKEN_LENGTH)) begin
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end else begin
                        tok_a_v   = 1'b1;
                        tok_a     = flush_tok;
                        pend_next = stt_pkg::PK_NONE;
                    end
                end
                stt_pkg::PK_MINUS, stt_pkg::PK_EQUAL: begin
                    tok_a_v   = 1'b1;
                    pend_next = stt_pkg::PK_NONE;
                    if (pend_reg == stt_pkg::PK_MINUS && c == stt_pkg::CHAR_GT) begin
                        done         = 1'b1;
                        tok_a.kind   = stt_pkg::KIND_ARROW;
                        tok_a.offset = start_off;
                        tok_a.length = 8'd2;
                    end else if (pend_reg == stt_pkg::PK_EQUAL && c == stt_pkg::CHAR_EQUAL) begin
                        done         = 1'b1;
                        tok_a.kind   = stt_pkg::KIND_EQEQ;
                        tok_a.offset = start_off;
                        tok_a.length = 8'd2;
                    end else begin
                        tok_a = flush_tok;
                    end
                end
                default: ;
            endcase

            if (!done) begin
                if (c == stt_pkg::CHAR_NUL) begin
                    tok_b_v      = 1'b1;
                    tok_b.kind   = stt_pkg::KIND_EOF;
                    tok_b.offset = pos_off;
                    pend_next    = stt_pkg::PK_NONE;
                    start_next   = '0;
                    cnt_next     = '0;
                    dot_next     = 1'b0;
                    fn_next      = 1'b0;
                    ret_next     = 1'b0;
                    pos_next     = '0;
                end else if (single != stt_pkg::KIND_EOF) begin
                    tok_b_v      = 1'b1;
                    tok_b.kind   = single;
                    tok_b.offset = pos_off;
                    tok_b.length = 8'd1;
                end else if (c == stt_pkg::CHAR_MINUS || c == stt_pkg::CHAR_EQUAL) begin
                    pend_next  = (c == stt_pkg::CHAR_MINUS) ? stt_pkg::PK_MINUS
                                                            : stt_pkg::PK_EQUAL;
                    start_next = pos_reg;
                end else if (stt_pkg::is_letter(c)) begin
                    pend_next  = stt_pkg::PK_IDENT;
                    start_next = pos_reg;
                    cnt_next   = CW'(1);
                    fn_next    = (c == stt_pkg::CHAR_F);
                    ret_next   = (c == stt_pkg::return_char(3'd0));
                end else if (stt_pkg::is_numeral(c)) begin
                    pend_next  = stt_pkg::PK_NUMBER;
                    start_next = pos_reg;
                    cnt_next   = CW'(1);
                    dot_next   = 1'b0;
                end
            end

            if (tok_b_v) begin
                tok_b.last = 1'b1;
            end else begin
                tok_a.last = 1'b1;
            end
        end
    end

    assign push_n    = {1'b0, tok_a_v} + {1'b0, tok_b_v};
    assign first_tok = tok_a_v ? tok_a : tok_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= stt_pkg::PK_NONE;
            pos_reg   <= '0;
            start_reg <= '0;
            cnt_reg   <= '0;
            dot_reg   <= 1'b0;
            fn_reg    <= 1'b0;
            ret_reg   <= 1'b0;
        end else begin
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            cnt_reg   <= cnt_next;
            dot_reg   <= dot_next;
            fn_reg    <= fn_next;
            ret_reg   <= ret_next;
        end
    end

    // Result queue control; a byte is taken only while two entries are free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + AW'(push_n);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_reg + QW'(push_n) - QW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            queue_reg[wr_ptr_reg] <= first_tok;
        end
        if (push_n == 2'd2) begin
            queue_reg[wr_ptr_reg + AW'(1)] <= tok_b;
        end
    end

    assign s_tready = (count_reg <= QW'(DEPTH - 2));
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {1'b0, queue_reg[rd_ptr_reg].which, queue_reg[rd_ptr_reg].length,
                       queue_reg[rd_ptr_reg].offset, queue_reg[rd_ptr_reg].kind};
    assign m_tlast  = queue_reg[rd_ptr_reg].last;

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QW'(DEPTH))
        else $error("result queue holds more entries than it has");

    a_eof_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tdata == stt_pkg::CHAR_NUL) |=>
            (pend_reg == stt_pkg::PK_NONE && pos_reg == '0))
        else $error("end of text did not return the tokenizer to reset state");

    a_pending_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg == stt_pkg::PK_IDENT || pend_reg == stt_pkg::PK_NUMBER) |->
            (cnt_reg != '0))
        else $error("pending identifier or number has no bytes");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_n != 2'd0) |-> (count_reg + QW'(push_n) <= QW'(DEPTH)))
        else $error("tokens pushed into a full result queue");
`endif

endmodule

>>> tb/sv/source_text_tokenizer_checker.sv
// Checker for the source text tokenizer: predicts the token stream and compares each transfer.
`timescale 1ns / 1ps

module stt_token_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          tokens_owed
);

    localparam logic [15:0] FN_WORD     = "fn";
    localparam logic [47:0] RETURN_WORD = "return";
    localparam logic [7:0]  LENGTH_CAP  = 8'd255;
    localparam logic [15:0] POS_TOP     = 16'hFFFF;

    stt_pkg::token_t expected_tokens[$];
    stt_pkg::token_t step_tokens[2];
    int              step_count;
    stt_pkg::token_t got;
    stt_pkg::token_t want;
    int              errors = 0;
    int              owed = 0;

    // Predicted tokenizer state.
    logic [15:0]     text_pos;
    logic [15:0]     tok_start;
    stt_pkg::pend_t  held;
    logic [7:0]      tok_len;
    logic            has_dot;
    logic            maybe_fn;
    logic            maybe_return;

    assign mismatch_count = errors;
    assign tokens_owed    = owed;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        case (c)
            "(":     return stt_pkg::KIND_LPAREN;
            ")":     return stt_pkg::KIND_RPAREN;
            "{":     return stt_pkg::KIND_LBRACE;
            "}":     return stt_pkg::KIND_RBRACE;
            ",":     return stt_pkg::KIND_COMMA;
            ":":     return stt_pkg::KIND_COLON;
            "+":     return stt_pkg::KIND_PLUS;
            "*":     return stt_pkg::KIND_STAR;
            "/":     return stt_pkg::KIND_SLASH;
            "%":     return stt_pkg::KIND_PERCENT;
            ".":     return stt_pkg::KIND_DOT;
            default: return stt_pkg::KIND_EOF;
        endcase
    endfunction

    task automatic clear_state();
        text_pos     = '0;
        tok_start    = '0;
        held         = stt_pkg::PK_NONE;
        tok_len      = '0;
        has_dot      = 1'b0;
        maybe_fn     = 1'b0;
        maybe_return = 1'b0;
    endtask

    task automatic add_token(input logic [4:0] kind, input logic [15:0] off,
                             input logic [7:0] len, input logic [1:0] which);
        step_tokens[step_count] = {kind, off, len, which, 1'b0};
        step_count++;
    endtask

    task automatic extend_ident(input logic [7:0] c);
        if (tok_len >= LENGTH_CAP) begin
            // A saturated identifier can no longer match either keyword.
            maybe_fn     = 1'b0;
            maybe_return = 1'b0;
        end else begin
            if (tok_len >= 2)
                maybe_fn = 1'b0;
            else if (FN_WORD[15 - 8 * tok_len -: 8] != c)
                maybe_fn = 1'b0;
            if (tok_len >= 6)
                maybe_return = 1'b0;
            else if (RETURN_WORD[47 - 8 * tok_len -: 8] != c)
                maybe_return = 1'b0;
            tok_len = tok_len + 8'd1;
        end
    endtask

    task automatic close_pending();
        case (held)
            stt_pkg::PK_IDENT: begin
                if (maybe_fn && tok_len == 8'd2)
                    add_token(stt_pkg::KIND_KEYWORD, tok_start, tok_len, stt_pkg::KW_FN);
                else if (maybe_return && tok_len == 8'd6)
                    add_token(stt_pkg::KIND_KEYWORD, tok_start, tok_len, stt_pkg::KW_RETURN);
                else
                    add_token(stt_pkg::KIND_IDENT, tok_start, tok_len, stt_pkg::KW_NONE);
            end
            stt_pkg::PK_NUMBER:
                add_token(stt_pkg::KIND_NUMBER, tok_start, tok_len, stt_pkg::KW_NONE);
            stt_pkg::PK_MINUS:
                add_token(stt_pkg::KIND_MINUS, tok_start, 8'd1, stt_pkg::KW_NONE);
            stt_pkg::PK_EQUAL:
                add_token(stt_pkg::KIND_ASSIGN, tok_start, 8'd1, stt_pkg::KW_NONE);
            default: ;
        endcase
        held = stt_pkg::PK_NONE;
    endtask

    task automatic tokenize_byte(input logic [7:0] c);
        logic            consumed;
        logic            ended;
        logic [15:0]     here;
        stt_pkg::token_t t;
        here       = text_pos;
        consumed   = 1'b0;
        ended      = 1'b0;
        step_count = 0;
        case (held)
            stt_pkg::PK_IDENT: begin
                if (is_alpha(c) || is_decimal(c) || c == stt_pkg::CHAR_UNDERSCORE) begin
                    extend_ident(c);
                    consumed = 1'b1;
                end else begin
                    close_pending();
                end
            end
            stt_pkg::PK_NUMBER: begin
                if (is_decimal(c)) begin
                    if (tok_len < LENGTH_CAP) tok_len = tok_len + 8'd1;
                    consumed = 1'b1;
                end else if (c == stt_pkg::CHAR_DOT && !has_dot) begin
                    has_dot = 1'b1;
                    if (tok_len < LENGTH_CAP) tok_len = tok_len + 8'd1;
                    consumed = 1'b1;
                end else begin
                    close_pending();
                end
            end
            stt_pkg::PK_MINUS: begin
                if (c == stt_pkg::CHAR_GT) begin
                    add_token(stt_pkg::KIND_ARROW, tok_start, 8'd2, stt_pkg::KW_NONE);
                    held     = stt_pkg::PK_NONE;
                    consumed = 1'b1;
                end else begin
                    close_pending();
                end
            end
            stt_pkg::PK_EQUAL: begin
                if (c == stt_pkg::CHAR_EQUAL) begin
                    add_token(stt_pkg::KIND_EQEQ, tok_start, 8'd2, stt_pkg::KW_NONE);
                    held     = stt_pkg::PK_NONE;
                    consumed = 1'b1;
                end else begin
                    close_pending();
                end
            end
            default: held = stt_pkg::PK_NONE;
        endcase

        if (!consumed) begin
            if (c == stt_pkg::CHAR_NUL) begin
                add_token(stt_pkg::KIND_EOF, here, 8'd0, stt_pkg::KW_NONE);
                clear_state();
                ended = 1'b1;
            end else if (punct_kind(c) != stt_pkg::KIND_EOF) begin
                add_token(punct_kind(c), here, 8'd1, stt_pkg::KW_NONE);
            end else if (c == stt_pkg::CHAR_MINUS) begin
                held      = stt_pkg::PK_MINUS;
                tok_start = here;
            end else if (c == stt_pkg::CHAR_EQUAL) begin
                held      = stt_pkg::PK_EQUAL;
                tok_start = here;
            end else if (is_alpha(c)) begin
                held         = stt_pkg::PK_IDENT;
                tok_start    = here;
                tok_len      = 8'd1;
                maybe_fn     = (c == FN_WORD[15:8]);
                maybe_return = (c == RETURN_WORD[47:40]);
            end else if (is_decimal(c)) begin
                held      = stt_pkg::PK_NUMBER;
                tok_start = here;
                tok_len   = 8'd1;
                has_dot   = 1'b0;
            end
        end

        // The position saturates rather than wrapping.
        if (!ended && text_pos != POS_TOP)
            text_pos = text_pos + 16'd1;

        for (int i = 0; i < step_count; i++) begin
            t      = step_tokens[i];
            t.last = (i == step_count - 1);
            expected_tokens.push_back(t);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            expected_tokens.delete();
        end else begin
            // Results are compared before the byte of this edge is predicted, as a byte's
            // tokens never leave in the cycle of its own transfer.
            if (m_tvalid && m_tready) begin
                got = {m_tdata[4:0], m_tdata[20:5], m_tdata[28:21], m_tdata[30:29], m_tlast};
                if (expected_tokens.size() == 0) begin
                    $display("%0t: unexpected token: expected none, actual kind %0d off %0d",
                             $time, got.kind, got.offset,
                             " len %0d which %0d last %0d", got.length, got.which, got.last);
                    errors++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (got !== want || m_tdata[31] !== 1'b0) begin
                        $display("%0t: token mismatch: expected kind %0d off %0d len %0d",
                                 $time, want.kind, want.offset, want.length,
                                 " which %0d last %0d pad 0, actual kind %0d off %0d",
                                 want.which, want.last, got.kind, got.offset,
                                 " len %0d which %0d last %0d pad %0d",
                                 got.length, got.which, got.last, m_tdata[31]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                tokenize_byte(s_tdata);
        end
        owed = expected_tokens.size();
    end

endmodule

>>> tb/sv/source_text_tokenizer_core_test.sv
// Top of the tokenizer testbench: clock, reset, byte stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module source_text_tokenizer_core_test;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_BYTES = 110;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int bytes_sent     = 0;
    int mismatch_count;
    int tokens_owed;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    source_text_tokenizer_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    stt_token_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .tokens_owed    (tokens_owed)
    );

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Ends the run if neither channel completes a transfer for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task send_byte(input logic [7:0] b);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task send_run(input logic [7:0] b, input int n);
        repeat (n) send_byte(b);
    endtask

    function logic [7:0] random_letter();
        return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25));
    endfunction

    function logic [7:0] random_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function logic [7:0] ident_tail_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return random_letter();
        if (r < 8) return random_digit();
        return stt_pkg::CHAR_UNDERSCORE;
    endfunction

    function logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0:       return " ";
            1:       return "\t";
            2:       return "\n";
            default: return 8'h0D;
        endcase
    endfunction

    // Keywords and the near misses around them.
    function string keyword_like(input int i);
        case (i)
            0:       return "fn";
            1:       return "return";
            2:       return "f";
            3:       return "fnn";
            4:       return "re";
            5:       return "retur";
            6:       return "returns";
            7:       return "rfn";
            8:       return "fn_";
            default: return "return9";
        endcase
    endfunction

    function string operator_text(input int i);
        case (i)
            0:       return "(";
            1:       return ")";
            2:       return "{";
            3:       return "}";
            4:       return ",";
            5:       return ":";
            6:       return "=";
            7:       return "+";
            8:       return "-";
            9:       return "*";
            10:      return "/";
            11:      return "%";
            12:      return ".";
            13:      return "->";
            14:      return "==";
            15:      return "=>";
            16:      return "-=";
            17:      return ">";
            default: return "===";
        endcase
    endfunction

    // Mostly well-formed lexemes, with some noise and an occasional end of text.
    task send_random_lexeme();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_byte(8'($urandom_range(1, 255)));
        end else if (pick < 11) begin
            send_byte(stt_pkg::CHAR_NUL);
        end else if (pick < 25) begin
            send_text(keyword_like($urandom_range(0, 9)));
        end else if (pick < 45) begin
            send_byte(random_letter());
            repeat ($urandom_range(0, 7)) send_byte(ident_tail_char());
        end else if (pick < 65) begin
            repeat ($urandom_range(1, 4)) send_byte(random_digit());
            if ($urandom_range(0, 99) < 60) begin
                send_byte(stt_pkg::CHAR_DOT);
                repeat ($urandom_range(0, 3)) send_byte(random_digit());
                if ($urandom_range(0, 99) < 15) begin
                    send_byte(stt_pkg::CHAR_DOT);
                    send_byte(random_digit());
                end
            end
        end else if (pick < 85) begin
            send_text(operator_text($urandom_range(0, 18)));
        end else begin
            send_byte(blank_char());
        end
        // Without a separator the next lexeme closes this one in the same byte.
        if ($urandom_range(0, 99) < 55) send_byte(blank_char());
    endtask

    task run_phase(input int idle_pct, input int stall_pct);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target         = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target) send_random_lexeme();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Every token kind, keyword near misses and the lookahead pairs.
        send_text("fn return f fnx retur returnx a_9Z (){},:=+-*/%. -> == 1.5 1. 2.3.4 -x =y");
        send_byte("\t");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        // A held minus, equals sign or identifier, and a punctuation byte, directly before the end of text.
        send_text("x-");
        send_byte(stt_pkg::CHAR_NUL);
        send_text("=");
        send_byte(stt_pkg::CHAR_NUL);
        send_text("abc");
        send_byte(stt_pkg::CHAR_NUL);
        send_text("7.9(");
        send_byte(stt_pkg::CHAR_NUL);

        // Saturating lengths for an identifier and for a number with a dot.
        send_byte("r");
        send_run("x", 300);
        send_byte(" ");
        send_run("7", 150);
        send_byte(stt_pkg::CHAR_DOT);
        send_run("3", 150);
        send_byte(stt_pkg::CHAR_DOT);
        send_byte(stt_pkg::CHAR_NUL);

        send_text("ab 1 -> x");
        send_byte(stt_pkg::CHAR_NUL);

        run_phase(0, 0);
        run_phase(50, 0);
        run_phase(0, 50);
        run_phase(14, 14);

        s_tvalid <= 1'b0;
        while (tokens_owed != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);

        if (mismatch_count == 0 && tokens_owed == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
